// ===== rtl/cdti_pkg.sv =====
// Shared types and constants of the cell delay table interpolator.
// Used by cdti_ctrl, cdti_dp and the top level; depends on nothing.
package cdti_pkg;

  localparam int TABLE_ROWS = 64;
  localparam int ADDR_W     = $clog2(TABLE_ROWS);
  localparam int CNT_W      = $clog2(TABLE_ROWS + 1);
  localparam int VAL_W      = 32;
  localparam int ROW_W      = 3 * VAL_W;
  localparam int MUL_W      = 65;
  localparam int IT_W       = 6;
  localparam logic [IT_W-1:0] MUL_LAST_IT = IT_W'(32);
  localparam logic [IT_W-1:0] DIV_LAST_IT = IT_W'(63);

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_AP_TEST, S_AP_CHK, S_AP_WR,
    S_SC_RD, S_SC_CALC, S_SC_MUL, S_SC_CMP, S_SC_NEXT,
    S_G_RD, S_G_CHK, S_DECIDE, S_L_MUL, S_DIV_LOAD, S_DIV, S_FIN, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_AP_START, CMD_AP_RD, CMD_AP_SHIFT, CMD_AP_WR,
    CMD_CLEAR, CMD_RES_FULL, CMD_RES_EMPTY, CMD_RES_ZERO, CMD_SC_INIT,
    CMD_SC_RD, CMD_SC_CALC, CMD_MUL_STEP, CMD_SC_CMP, CMD_SC_NEXT,
    CMD_G_INIT, CMD_G_RD, CMD_G_CHK, CMD_DECIDE, CMD_DIV_LOAD,
    CMD_DIV_STEP, CMD_FIN, CMD_PUBLISH
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       empty;
    logic       idx_zero;
    logic       idx_last;
    logic       greater;
    logic       it_last;
    logic       in_group;
    logic       direct;
  } dp_status_t;

  typedef struct packed {
    logic [VAL_W-1:0] c0;
    logic [VAL_W-1:0] d0;
    logic [VAL_W-1:0] c1;
    logic [VAL_W-1:0] d1;
  } pair_t;

endpackage

// ===== rtl/cell_delay_table_interpolator_unit.sv =====
// Top level of the cell delay table interpolator: stream ports, sequencer
// and datapath. Depends on cdti_pkg, cdti_ctrl and cdti_dp.
//
// Holds up to 64 timing rows (transition, load, delay), kept sorted, and
// answers delay queries by snapping to the nearest table transition and
// interpolating over load. One beat is worked on at a time; every input beat
// yields exactly one output beat. An append moves each larger row up by one to
// make room before it writes the new row. A query scans all rows, with a serial
// cross-multiply for the snap on every row after the first, then reads the
// snapped group row by row, and then, unless a row gives the result directly,
// runs the serial multiplier and the 64-step divider. The output register lets
// the next beat be taken while a result waits.
module cell_delay_table_interpolator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // transition[31:0], load_cap[63:32], row_delay[95:64]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // delay[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import cdti_pkg::*;

  cmd_t       cmd;
  dp_status_t st;

  cdti_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  cdti_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_mode    (in_tuser),
    .in_row     (in_tdata),
    .st         (st),
    .out_delay  (out_tdata),
    .out_status (out_tuser)
  );

endmodule

// ===== rtl/cdti_ctrl.sv =====
// Sequencer of the cell delay table interpolator: walks append, clear and
// query through their steps and issues at most one datapath command per cycle.
// Depends on cdti_pkg.
module cdti_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  cdti_pkg::dp_status_t  st,
  output cdti_pkg::cmd_t        cmd
);
  import cdti_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = CMD_NONE;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.mode)
          MODE_APPEND: begin
            if (st.full) begin
              cmd       = CMD_RES_FULL;
              state_nxt = S_DONE;
            end else begin
              cmd       = CMD_AP_START;
              state_nxt = S_AP_TEST;
            end
          end
          MODE_CLEAR: begin
            cmd       = CMD_CLEAR;
            state_nxt = S_DONE;
          end
          MODE_QUERY: begin
            if (st.empty) begin
              cmd       = CMD_RES_EMPTY;
              state_nxt = S_DONE;
            end else begin
              cmd       = CMD_SC_INIT;
              state_nxt = S_SC_RD;
            end
          end
          default: begin
            cmd       = CMD_RES_ZERO;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_AP_TEST: begin
        if (st.idx_zero) begin
          state_nxt = S_AP_WR;
        end else begin
          cmd       = CMD_AP_RD;
          state_nxt = S_AP_CHK;
        end
      end
      S_AP_CHK: begin
        if (st.greater) begin
          cmd       = CMD_AP_SHIFT;
          state_nxt = S_AP_TEST;
        end else begin
          state_nxt = S_AP_WR;
        end
      end
      S_AP_WR: begin
        cmd       = CMD_AP_WR;
        state_nxt = S_DONE;
      end
      S_SC_RD: begin
        cmd       = CMD_SC_RD;
        state_nxt = S_SC_CALC;
      end
      S_SC_CALC: begin
        cmd       = CMD_SC_CALC;
        state_nxt = st.idx_zero ? S_SC_NEXT : S_SC_MUL;
      end
      S_SC_MUL: begin
        cmd = CMD_MUL_STEP;
        if (st.it_last) state_nxt = S_SC_CMP;
      end
      S_SC_CMP: begin
        cmd       = CMD_SC_CMP;
        state_nxt = S_SC_NEXT;
      end
      S_SC_NEXT: begin
        if (st.idx_last) begin
          cmd       = CMD_G_INIT;
          state_nxt = S_G_RD;
        end else begin
          cmd       = CMD_SC_NEXT;
          state_nxt = S_SC_RD;
        end
      end
      S_G_RD: begin
        cmd       = CMD_G_RD;
        state_nxt = S_G_CHK;
      end
      S_G_CHK: begin
        cmd = CMD_G_CHK;
        if (!st.in_group || st.idx_last) state_nxt = S_DECIDE;
        else                             state_nxt = S_G_RD;
      end
      S_DECIDE: begin
        cmd       = CMD_DECIDE;
        state_nxt = st.direct ? S_DONE : S_L_MUL;
      end
      S_L_MUL: begin
        cmd = CMD_MUL_STEP;
        if (st.it_last) state_nxt = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        cmd       = CMD_DIV_LOAD;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd = CMD_DIV_STEP;
        if (st.it_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd       = CMD_FIN;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd           = CMD_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/cdti_dp.sv =====
// Datapath of the cell delay table interpolator: row memory, row count,
// snap/group scan registers, serial multipliers and restoring divider.
// Depends on cdti_pkg; driven by cdti_ctrl commands.
module cdti_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cdti_pkg::cmd_t             cmd,
  input  logic [1:0]                 in_mode,
  input  logic [cdti_pkg::ROW_W-1:0] in_row,
  output cdti_pkg::dp_status_t       st,
  output logic [cdti_pkg::VAL_W-1:0] out_delay,
  output logic [1:0]                 out_status
);
  import cdti_pkg::*;

  localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [63:0]      QUO_LIM = 64'h0000_0100_0000_0000;

  logic [ROW_W-1:0] mem [TABLE_ROWS];
  logic [ROW_W-1:0] rd_q;
  logic [CNT_W-1:0] cnt_r, idx_r;
  logic [1:0]       mode_r;
  logic [VAL_W-1:0] t_r, q_r, dl_in_r;

  logic [VAL_W-1:0] bn_r, cn_r;
  logic [VAL_W:0]   bd_r, cd_r;
  logic [ADDR_W-1:0] best_r;
  logic [MUL_W-1:0] mc1_r, mc2_r, acc1_r, acc2_r;
  logic [VAL_W:0]   mp1_r, mp2_r;
  logic [IT_W-1:0]  it_r;

  logic [VAL_W-1:0] snap_r, ld_lo_r, dl_lo_r, prev_ld_r, prev_dl_r, match_dl_r;
  logic             gmulti_r, match_r;
  pair_t            fp_r, lp_r, mp_r;

  logic [VAL_W-1:0] den_r, d0_r;
  logic             neg_r;
  logic [VAL_W:0]   rem_r;
  logic [63:0]      nq_r;

  logic [VAL_W-1:0] res_delay_r;
  logic [1:0]       res_status_r;
  logic [VAL_W-1:0] out_delay_r;
  logic [1:0]       out_status_r;

  logic [VAL_W-1:0] r_tr, r_ld, r_dl;
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0] dn;
  logic [VAL_W:0]   dd;
  logic             first;

  // decision over the captured group
  logic             dir;
  logic [VAL_W-1:0] dir_val;
  pair_t            sel;
  logic [VAL_W-1:0] la, lb, lden;
  logic             lneg;
  logic [VAL_W:0]   rsh;
  logic [42:0]      lv;

  assign r_tr = rd_q[VAL_W-1:0];
  assign r_ld = rd_q[2*VAL_W-1:VAL_W];
  assign r_dl = rd_q[ROW_W-1:2*VAL_W];
  assign first = (idx_r == CNT_W'(best_r));

  always_comb begin
    if (cmd == CMD_AP_RD) rd_addr = ADDR_W'(idx_r - CNT_W'(1));
    else                  rd_addr = idx_r[ADDR_W-1:0];
  end

  always_comb begin
    dn = (r_tr >= t_r) ? r_tr - t_r : t_r - r_tr;
    dd = {1'b0, r_tr} + {1'b0, t_r};
    if (dd == '0) begin
      dn = '0;
      dd = (VAL_W+1)'(1);
    end
  end

  always_comb begin
    dir     = 1'b0;
    dir_val = '0;
    sel     = mp_r;
    if (match_r) begin
      dir     = 1'b1;
      dir_val = match_dl_r;
    end else if (!gmulti_r) begin
      dir     = 1'b1;
      dir_val = dl_lo_r;
    end else if (q_r < ld_lo_r) begin
      sel = fp_r;
      if (fp_r.c0 == fp_r.c1) begin
        dir     = 1'b1;
        dir_val = fp_r.d0;
      end
    end else if (q_r > lp_r.c1) begin
      sel = lp_r;
      if (lp_r.c0 == lp_r.c1) begin
        dir     = 1'b1;
        dir_val = lp_r.d1;
      end
    end
    la   = (q_r >= sel.c0) ? q_r - sel.c0 : sel.c0 - q_r;
    lb   = (sel.d1 >= sel.d0) ? sel.d1 - sel.d0 : sel.d0 - sel.d1;
    lden = (sel.c1 >= sel.c0) ? sel.c1 - sel.c0 : sel.c0 - sel.c1;
    lneg = (q_r < sel.c0) ^ (sel.d1 < sel.d0) ^ (sel.c1 < sel.c0);
  end

  assign rsh = {rem_r[VAL_W-1:0], nq_r[63]};
  assign lv  = neg_r ? {11'b0, d0_r} - {2'b0, nq_r[40:0]}
                     : {11'b0, d0_r} + {2'b0, nq_r[40:0]};

  always_comb begin
    st.mode     = mode_r;
    st.full     = (cnt_r >= CNT_W'(TABLE_ROWS));
    st.empty    = (cnt_r == '0);
    st.idx_zero = (idx_r == '0);
    st.idx_last = (idx_r + CNT_W'(1) == cnt_r);
    st.greater  = (r_tr > t_r) || (r_tr == t_r && r_ld > q_r);
    st.it_last  = (it_r == '0);
    st.in_group = first || (r_tr == snap_r);
    st.direct   = dir;
  end

  // row memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd == CMD_AP_SHIFT) mem[idx_r[ADDR_W-1:0]] <= rd_q;
    else if (cmd == CMD_AP_WR) mem[idx_r[ADDR_W-1:0]] <= {dl_in_r, q_r, t_r};
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd == CMD_CLEAR) cnt_r <= '0;
    else if (cmd == CMD_AP_WR) cnt_r <= cnt_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        mode_r  <= in_mode;
        t_r     <= in_row[VAL_W-1:0];
        q_r     <= in_row[2*VAL_W-1:VAL_W];
        dl_in_r <= in_row[ROW_W-1:2*VAL_W];
      end
      CMD_AP_START: idx_r <= cnt_r;
      CMD_AP_SHIFT: idx_r <= idx_r - CNT_W'(1);
      CMD_AP_WR: begin
        res_delay_r  <= '0;
        res_status_r <= ST_OK;
      end
      CMD_CLEAR, CMD_RES_ZERO: begin
        res_delay_r  <= '0;
        res_status_r <= ST_OK;
      end
      CMD_RES_FULL: begin
        res_delay_r  <= '0;
        res_status_r <= ST_FULL;
      end
      CMD_RES_EMPTY: begin
        res_delay_r  <= '0;
        res_status_r <= ST_EMPTY;
      end
      CMD_SC_INIT: idx_r <= '0;
      CMD_SC_CALC: begin
        if (idx_r == '0) begin
          bn_r   <= dn;
          bd_r   <= dd;
          best_r <= '0;
        end
        cn_r   <= dn;
        cd_r   <= dd;
        mc1_r  <= MUL_W'(dn);
        mp1_r  <= bd_r;
        mc2_r  <= MUL_W'(bn_r);
        mp2_r  <= dd;
        acc1_r <= '0;
        acc2_r <= '0;
        it_r   <= MUL_LAST_IT;
      end
      CMD_MUL_STEP: begin
        if (mp1_r[0]) acc1_r <= acc1_r + mc1_r;
        if (mp2_r[0]) acc2_r <= acc2_r + mc2_r;
        mc1_r <= mc1_r << 1;
        mc2_r <= mc2_r << 1;
        mp1_r <= mp1_r >> 1;
        mp2_r <= mp2_r >> 1;
        it_r  <= it_r - IT_W'(1);
      end
      CMD_SC_CMP: begin
        // cross-multiplied relative distance; ties keep the earlier row
        if (acc1_r < acc2_r) begin
          bn_r   <= cn_r;
          bd_r   <= cd_r;
          best_r <= idx_r[ADDR_W-1:0];
        end
      end
      CMD_SC_NEXT: idx_r <= idx_r + CNT_W'(1);
      CMD_G_INIT: idx_r <= CNT_W'(best_r);
      CMD_G_CHK: begin
        if (st.in_group) begin
          if (first) begin
            snap_r     <= r_tr;
            ld_lo_r    <= r_ld;
            dl_lo_r    <= r_dl;
            gmulti_r   <= 1'b0;
            match_r    <= (r_ld == q_r);
            match_dl_r <= r_dl;
          end else begin
            gmulti_r <= 1'b1;
            lp_r     <= '{c0: prev_ld_r, d0: prev_dl_r, c1: r_ld, d1: r_dl};
            if (idx_r == CNT_W'(best_r) + CNT_W'(1))
              fp_r <= '{c0: prev_ld_r, d0: prev_dl_r, c1: r_ld, d1: r_dl};
            if (prev_ld_r < q_r)
              mp_r <= '{c0: prev_ld_r, d0: prev_dl_r, c1: r_ld, d1: r_dl};
            if (!match_r && r_ld == q_r) begin
              match_r    <= 1'b1;
              match_dl_r <= r_dl;
            end
          end
          prev_ld_r <= r_ld;
          prev_dl_r <= r_dl;
          idx_r     <= idx_r + CNT_W'(1);
        end
      end
      CMD_DECIDE: begin
        if (dir_val > POS_MAX) begin
          res_delay_r  <= POS_MAX;
          res_status_r <= ST_SAT;
        end else begin
          res_delay_r  <= dir_val;
          res_status_r <= ST_OK;
        end
        den_r  <= lden;
        d0_r   <= sel.d0;
        neg_r  <= lneg;
        mc1_r  <= MUL_W'(la);
        mp1_r  <= (VAL_W+1)'(lb);
        mc2_r  <= '0;
        mp2_r  <= '0;
        acc1_r <= '0;
        acc2_r <= '0;
        it_r   <= MUL_LAST_IT;
      end
      CMD_DIV_LOAD: begin
        nq_r  <= acc1_r[63:0] + 64'(den_r >> 1);
        rem_r <= '0;
        it_r  <= DIV_LAST_IT;
      end
      CMD_DIV_STEP: begin
        if (rsh >= {1'b0, den_r}) begin
          rem_r <= rsh - {1'b0, den_r};
          nq_r  <= {nq_r[62:0], 1'b1};
        end else begin
          rem_r <= rsh;
          nq_r  <= {nq_r[62:0], 1'b0};
        end
        it_r <= it_r - IT_W'(1);
      end
      CMD_FIN: begin
        if (nq_r > QUO_LIM) begin
          res_delay_r  <= neg_r ? NEG_MIN : POS_MAX;
          res_status_r <= ST_SAT;
        end else if ($signed(lv) > $signed(43'(POS_MAX))) begin
          res_delay_r  <= POS_MAX;
          res_status_r <= ST_SAT;
        end else if ($signed(lv) < $signed({{11{1'b1}}, NEG_MIN})) begin
          res_delay_r  <= NEG_MIN;
          res_status_r <= ST_SAT;
        end else begin
          res_delay_r  <= lv[VAL_W-1:0];
          res_status_r <= ST_OK;
        end
      end
      CMD_PUBLISH: begin
        out_delay_r  <= res_delay_r;
        out_status_r <= res_status_r;
      end
      default: ;
    endcase
  end

  assign out_delay  = out_delay_r;
  assign out_status = out_status_r;

endmodule
